### rtl/imm_pkg.sv
// Shared types and constants for the integer matrix multiply unit.
// Depends on nothing; every other file but imm_ram uses it by scoped names.
`timescale 1ns / 1ps

package imm_pkg;

  localparam int DIM_W     = 4;
  localparam int FUNC_W    = 2;
  localparam int IDX_W     = 3;
  localparam int DATA_W    = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [FUNC_W-1:0] FUNC_LOAD_A  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_B  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_COMPUTE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic load;
    logic start;
    logic issue;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic k_last;
    logic elem_last;
    logic busy;
    logic out_free;
  } stat_t;

endpackage

### rtl/imm_in_if.sv
// Input channel of the matrix multiply unit: valid, ready and one item.
// Depends on imm_pkg.
`timescale 1ns / 1ps

interface imm_in_if;
  logic                              valid;
  logic                              ready;
  logic [imm_pkg::FUNC_W-1:0]        func;
  logic [imm_pkg::IDX_W-1:0]         row;
  logic [imm_pkg::IDX_W-1:0]         col;
  logic signed [imm_pkg::DATA_W-1:0] value;

  modport source (output valid, output func, output row, output col, output value,
                  input ready);
  modport sink (input valid, input func, input row, input col, input value,
                output ready);
endinterface

### rtl/imm_out_if.sv
// Result channel of the matrix multiply unit: valid, ready and one element.
// Depends on imm_pkg.
`timescale 1ns / 1ps

interface imm_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [imm_pkg::DATA_W-1:0] product;
  logic [imm_pkg::IDX_W-1:0]         out_row;
  logic [imm_pkg::IDX_W-1:0]         out_col;
  logic                              last;

  modport source (output valid, output product, output out_row, output out_col,
                  output last, input ready);
  modport sink (input valid, input product, input out_row, input out_col,
                input last, output ready);
endinterface

### rtl/imm_cfg_if.sv
// Configuration write channel of the matrix multiply unit.
// Depends on imm_pkg.
`timescale 1ns / 1ps

interface imm_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [imm_pkg::CFG_IDX_W-1:0]     index;
  logic [imm_pkg::DIM_W-1:0]         data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/imm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module imm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/imm_ctrl.sv
// Sequencing state machine of the matrix multiply unit.
// Depends on imm_pkg; drives datapath commands from datapath status.
`timescale 1ns / 1ps

module imm_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [imm_pkg::FUNC_W-1:0] in_func,
  output logic                       in_ready,
  input  imm_pkg::stat_t             st,
  output imm_pkg::cmd_t              cmd
);

  imm_pkg::state_t state_r;
  imm_pkg::state_t state_nxt;
  logic            emit_ok;

  assign emit_ok = !st.busy && st.out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= imm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      imm_pkg::ST_IDLE: begin
        if (in_valid && in_func == imm_pkg::FUNC_COMPUTE) begin
          state_nxt = imm_pkg::ST_ISSUE;
        end
      end
      imm_pkg::ST_ISSUE: begin
        if (st.k_last) begin
          state_nxt = imm_pkg::ST_DRAIN;
        end
      end
      imm_pkg::ST_DRAIN: begin
        if (emit_ok) begin
          state_nxt = st.elem_last ? imm_pkg::ST_IDLE : imm_pkg::ST_ISSUE;
        end
      end
      default: state_nxt = imm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      imm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_func == imm_pkg::FUNC_COMPUTE) begin
            cmd.start = 1'b1;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      imm_pkg::ST_ISSUE: begin
        cmd.issue = 1'b1;
      end
      imm_pkg::ST_DRAIN: begin
        cmd.emit = emit_ok;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

### rtl/imm_datapath.sv
// Datapath of the matrix multiply unit: size registers, element stores,
// multiply-accumulate pipeline, loop counters and the result register.
// Depends on imm_pkg, imm_ram and the imm_cfg_if and imm_out_if channel interfaces.
`timescale 1ns / 1ps

module imm_datapath #(
  parameter int unsigned MAX_DIM = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  imm_pkg::cmd_t                     cmd,
  output imm_pkg::stat_t                    st,
  input  logic [imm_pkg::FUNC_W-1:0]        in_func,
  input  logic [imm_pkg::IDX_W-1:0]         in_row,
  input  logic [imm_pkg::IDX_W-1:0]         in_col,
  input  logic signed [imm_pkg::DATA_W-1:0] in_value,
  imm_cfg_if.sink                           cfg_chan,
  imm_out_if.source                         out_chan
);

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DW = imm_pkg::DIM_W;
  localparam int XW = imm_pkg::DATA_W;

  function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] v);
    logic [DW-1:0] res;
    if (v == '0) begin
      res = DW'(1);
    end else if (32'(v) > MAX_DIM) begin
      res = DW'(MAX_DIM);
    end else begin
      res = v;
    end
    return res;
  endfunction

  logic [DW-1:0]    rows_r, inner_r, cols_r;
  logic [IW-1:0]    i_r, j_r, k_r;
  logic             i_last, j_last, k_last;
  logic             ld_a, ld_b;
  logic [AW-1:0]    ld_addr, a_raddr, b_raddr;
  logic [XW-1:0]    a_rd, b_rd, a_op, b_op;
  logic [DEPTH-1:0] a_vld_r, a_vld_nxt, b_vld_r, b_vld_nxt;
  logic             av_r, bv_r;
  logic             v1_r, v2_r;
  logic [XW-1:0]    prod_r, prod_nxt;
  logic [XW-1:0]    acc_r, acc_nxt;
  logic             out_valid_r;
  logic [XW-1:0]    product_r;
  logic [imm_pkg::IDX_W-1:0] row_r, col_r;
  logic             last_r;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r  <= DW'(MAX_DIM);
      inner_r <= DW'(MAX_DIM);
      cols_r  <= DW'(MAX_DIM);
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        imm_pkg::REG_ROWS_A:    rows_r  <= clamp_dim(cfg_chan.data);
        imm_pkg::REG_INNER_DIM: inner_r <= clamp_dim(cfg_chan.data);
        imm_pkg::REG_COLS_B:    cols_r  <= clamp_dim(cfg_chan.data);
        default: ;
      endcase
    end
  end

  assign ld_a = cmd.load && in_func == imm_pkg::FUNC_LOAD_A
                && DW'(in_row) < rows_r && DW'(in_col) < inner_r;
  assign ld_b = cmd.load && in_func == imm_pkg::FUNC_LOAD_B
                && DW'(in_row) < inner_r && DW'(in_col) < cols_r;
  assign ld_addr = AW'(32'(in_row) * MAX_DIM + 32'(in_col));
  assign a_raddr = AW'(32'(i_r) * MAX_DIM + 32'(k_r));
  assign b_raddr = AW'(32'(k_r) * MAX_DIM + 32'(j_r));

  imm_ram #(.WIDTH(XW), .DEPTH(DEPTH)) u_store_a (
    .clk   (clk),
    .we    (ld_a),
    .waddr (ld_addr),
    .wdata (in_value),
    .raddr (a_raddr),
    .rdata (a_rd)
  );

  imm_ram #(.WIDTH(XW), .DEPTH(DEPTH)) u_store_b (
    .clk   (clk),
    .we    (ld_b),
    .waddr (ld_addr),
    .wdata (in_value),
    .raddr (b_raddr),
    .rdata (b_rd)
  );

  // An entry never written since reset reads as zero.
  always_comb begin
    a_vld_nxt = a_vld_r;
    b_vld_nxt = b_vld_r;
    if (ld_a) begin
      a_vld_nxt[ld_addr] = 1'b1;
    end
    if (ld_b) begin
      b_vld_nxt[ld_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= '0;
      b_vld_r <= '0;
    end else begin
      a_vld_r <= a_vld_nxt;
      b_vld_r <= b_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    av_r <= a_vld_r[a_raddr];
    bv_r <= b_vld_r[b_raddr];
  end

  assign a_op     = av_r ? a_rd : '0;
  assign b_op     = bv_r ? b_rd : '0;
  assign prod_nxt = a_op * b_op;

  always_comb begin
    acc_nxt = acc_r;
    if (cmd.start || cmd.emit) begin
      acc_nxt = '0;
    end else if (v2_r) begin
      acc_nxt = acc_r + prod_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

  assign k_last = (DW'(k_r) + DW'(1)) == inner_r;
  assign j_last = (DW'(j_r) + DW'(1)) == cols_r;
  assign i_last = (DW'(i_r) + DW'(1)) == rows_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r <= '0;
      j_r <= '0;
      k_r <= '0;
    end else if (cmd.start) begin
      i_r <= '0;
      j_r <= '0;
      k_r <= '0;
    end else begin
      if (cmd.issue) begin
        k_r <= k_last ? '0 : k_r + IW'(1);
      end
      if (cmd.emit && !(i_last && j_last)) begin
        if (j_last) begin
          j_r <= '0;
          i_r <= i_r + IW'(1);
        end else begin
          j_r <= j_r + IW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      product_r <= acc_r;
      row_r     <= imm_pkg::IDX_W'(i_r);
      col_r     <= imm_pkg::IDX_W'(j_r);
      last_r    <= i_last && j_last;
    end
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.product = product_r;
  assign out_chan.out_row = row_r;
  assign out_chan.out_col = col_r;
  assign out_chan.last    = last_r;

  assign st.k_last    = k_last;
  assign st.elem_last = i_last && j_last;
  assign st.busy      = v1_r || v2_r;
  assign st.out_free  = !out_valid_r || out_chan.ready;

endmodule

### rtl/integer_matrix_multiply_unit.sv
// A load transfer is taken whenever the unit is idle; a compute transfer blocks the input
// until its last element has been placed in the result register.
// Each product element is summed, one element at a time, by the single
// multiply-accumulate path behind the registered store reads.
// Synchronous active-low reset sets all sizes to MAX_DIM and makes both stores
// read as zero at once through per-entry valid flags; no clearing pass.
`timescale 1ns / 1ps

module integer_matrix_multiply_unit #(
  parameter int unsigned MAX_DIM = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  imm_in_if.sink     in_chan,
  imm_cfg_if.sink    cfg_chan,
  imm_out_if.source  out_chan
);

  imm_pkg::cmd_t  cmd;
  imm_pkg::stat_t st;
  logic           in_ready;

  assign in_chan.ready = in_ready;

  imm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_func  (in_chan.func),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  imm_datapath #(.MAX_DIM(MAX_DIM)) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .st       (st),
    .in_func  (in_chan.func),
    .in_row   (in_chan.row),
    .in_col   (in_chan.col),
    .in_value (in_chan.value),
    .cfg_chan (cfg_chan),
    .out_chan (out_chan)
  );

`ifndef SYNTHESIS
  a_compute_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready && in_chan.func == imm_pkg::FUNC_COMPUTE
    |=> !in_chan.ready)
    else $error("input ready after a compute transfer");

  a_start_then_issue: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> cmd.issue)
    else $error("compute start not followed by an issue");

  a_emit_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !st.busy && st.out_free)
    else $error("element emitted while pipeline busy or output full");
`endif

endmodule
